// ===== rtl/core/cdas_pkg.sv =====
package cdas_pkg;

    localparam int unsigned YEAR_W   = 16;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned NYEARS_W = 14;
    localparam int unsigned NMONS_W  = 12;
    localparam int unsigned NDAYS_W  = 16;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // One request as it enters the sequencer.
    typedef struct packed {
        logic [NDAYS_W-1:0]  ndays;
        logic [NMONS_W-1:0]  nmonths;
        logic [NYEARS_W-1:0] nyears;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic                cmd;
    } req_t;

    // One resulting date; the packing order matches the result tdata.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // Number of days in a month (1..12) for a leap or common year.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/cdas_leap.sv =====
module cdas_leap
    import cdas_pkg::*;
(
    input  logic              aclk,
    input  logic [YEAR_W-1:0] year,
    output logic              leap
);

    // A signed 16-bit year is a multiple of 25 exactly when its product with
    // the inverse of 25 modulo 2^16 lands within +/-1310 (32768 / 25).
    localparam logic [YEAR_W-1:0] INV25    = 16'd23593;
    localparam logic [YEAR_W-1:0] K_LIMIT  = 16'd1310;
    localparam logic [YEAR_W-1:0] K_NEGLIM = 16'd64226;

    logic [YEAR_W-1:0] prod;
    logic              div25;
    logic              leap_reg;
    logic              leap_next;

    assign prod  = YEAR_W'(year * INV25);
    assign div25 = (prod <= K_LIMIT) || (prod >= K_NEGLIM);

    // Divisible by 4, and a century only when also divisible by 16 (i.e. by 400).
    assign leap_next = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

    always_ff @(posedge aclk) begin
        leap_reg <= leap_next;
    end

    assign leap = leap_reg;

endmodule

// ===== rtl/core/cdas_alu.sv =====
module cdas_alu
    import cdas_pkg::*;
(
    input  logic [YEAR_W-1:0] a,
    input  logic [YEAR_W-1:0] b,
    input  logic              sub,
    output logic [YEAR_W-1:0] sum
);

    // Shared year adder; wraps modulo 2^16 as the year does.
    assign sum = sub ? (a - b) : (a + b);

endmodule

// ===== rtl/core/cdas_seq.sv =====
module cdas_seq
    import cdas_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    input  logic  res_free,
    output logic  res_valid,
    output date_t res
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_YEARS  = 6'b000010,
        ST_MONS   = 6'b000100,
        ST_MFIX   = 6'b001000,
        ST_SETTLE = 6'b010000,
        ST_DAYS   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [NYEARS_W-1:0] ny_reg, ny_next;
    logic [NMONS_W-1:0]  mcnt_reg, mcnt_next;
    logic [NDAYS_W-1:0]  nd_reg, nd_next;

    logic [YEAR_W-1:0]   alu_b;
    logic [YEAR_W-1:0]   alu_sum;
    logic                leap;
    logic [DAY_W-1:0]    dim;
    logic [DAY_W-1:0]    prev_len;
    logic [MONTH_W:0]    madd;
    logic [MONTH_W-1:0]  mrem;

    // The year only ever moves by the whole-year amount or by one, in the
    // direction of the command.
    assign alu_b = (state_reg == ST_YEARS) ? YEAR_W'(ny_reg) : YEAR_W'(1);

    cdas_alu u_alu (
        .a   (year_reg),
        .b   (alu_b),
        .sub (cmd_reg),
        .sum (alu_sum)
    );

    cdas_leap u_leap (
        .aclk (aclk),
        .year (year_reg),
        .leap (leap)
    );

    assign dim      = month_len(month_reg, leap);
    assign prev_len = month_len(month_reg - 4'd1, leap);
    assign mrem     = mcnt_reg[MONTH_W-1:0];
    assign madd     = {1'b0, month_reg} + {1'b0, mrem} - 5'd1;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        ny_next    = ny_reg;
        mcnt_next  = mcnt_reg;
        nd_next    = nd_reg;
        res_valid  = 1'b0;
        res.year   = year_reg;
        res.month  = month_reg;
        res.day    = (day_reg > dim) ? dim : day_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    cmd_next   = req.cmd;
                    year_next  = req.year;
                    ny_next    = req.nyears;
                    mcnt_next  = req.nmonths;
                    nd_next    = req.ndays;
                    day_next   = (req.day == '0) ? 5'd1 : req.day;
                    if (req.month == '0) begin
                        month_next = MONTH_JAN;
                    end else if (req.month > MONTHS_PER_YEAR) begin
                        month_next = MONTH_DEC;
                    end else begin
                        month_next = req.month;
                    end
                    state_next = ST_YEARS;
                end
            end
            ST_YEARS: begin
                year_next  = alu_sum;
                state_next = ST_MONS;
            end
            ST_MONS: begin
                // Fold whole years out of the month count, one per cycle.
                if (mcnt_reg >= NMONS_W'(MONTHS_PER_YEAR)) begin
                    mcnt_next = mcnt_reg - NMONS_W'(MONTHS_PER_YEAR);
                    year_next = alu_sum;
                end else begin
                    state_next = ST_MFIX;
                end
            end
            ST_MFIX: begin
                if (cmd_reg == CMD_ADD) begin
                    if (madd >= {1'b0, MONTHS_PER_YEAR}) begin
                        month_next = MONTH_W'(madd - 5'd11);
                        year_next  = alu_sum;
                    end else begin
                        month_next = MONTH_W'(madd + 5'd1);
                    end
                end else begin
                    if (month_reg <= mrem) begin
                        month_next = month_reg + MONTHS_PER_YEAR - mrem;
                        year_next  = alu_sum;
                    end else begin
                        month_next = month_reg - mrem;
                    end
                end
                state_next = ST_SETTLE;
            end
            ST_SETTLE: begin
                state_next = ST_DAYS;
            end
            ST_DAYS: begin
                if (nd_reg == '0) begin
                    if (res_free) begin
                        res_valid  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    nd_next = nd_reg - NDAYS_W'(1);
                    if (cmd_reg == CMD_ADD) begin
                        if (day_reg >= dim) begin
                            day_next = 5'd1;
                            if (month_reg == MONTH_DEC) begin
                                month_next = MONTH_JAN;
                                year_next  = alu_sum;
                            end else begin
                                month_next = month_reg + 4'd1;
                            end
                        end else begin
                            day_next = day_reg + 5'd1;
                        end
                    end else begin
                        if (day_reg == 5'd1) begin
                            if (month_reg == MONTH_JAN) begin
                                month_next = MONTH_DEC;
                                day_next   = 5'd31;
                                year_next  = alu_sum;
                            end else begin
                                month_next = month_reg - 4'd1;
                                day_next   = prev_len;
                            end
                        end else begin
                            day_next = day_reg - 5'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        ny_reg    <= ny_next;
        mcnt_reg  <= mcnt_next;
        nd_reg    <= nd_next;
    end

endmodule

// ===== rtl/core/calendar_date_add_subtract.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+-------------------------------------------------------------
// s_       | in  | one request: start date, command, years/months/days amounts
// m_       | out | one result: the resulting date
//
// An accepted beat passes the year add, the month fold, the month fix, a settle state and
// the day stepping loop before its result is valid. The day loop steps one day per cycle;
// the month count is folded into the year twelve months per cycle through the year adder.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A finished result waits in the output register while a new request is taken; the
// sequencer holds its next result until the waiting one leaves.
module calendar_date_add_subtract
    import cdas_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // start_year[15:0], start_month[19:16], start_day[24:20], num_years[38:25],
    // num_months[50:39], num_days[66:51], zeros[71:67]
    input  logic [71:0] s_tdata,
    // cmd[0]: 0 adds the amounts, 1 subtracts them
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // result_year[15:0], result_month[19:16], result_day[24:20], zeros[31:25]
    output logic [31:0] m_tdata
);

    req_t  req;
    date_t seq_res;
    logic  seq_done;
    logic  res_free;

    logic  m_tvalid_reg, m_tvalid_next;
    date_t out_reg, out_next;

    // Unpack the request beat; the field order follows the tdata comment above.
    assign req.cmd     = s_tuser;
    assign req.year    = s_tdata[15:0];
    assign req.month   = s_tdata[19:16];
    assign req.day     = s_tdata[24:20];
    assign req.nyears  = s_tdata[38:25];
    assign req.nmonths = s_tdata[50:39];
    assign req.ndays   = s_tdata[66:51];

    // The output register may be refilled when it is empty or being drained.
    assign res_free = !m_tvalid_reg || m_tready;

    cdas_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_free  (res_free),
        .res_valid (seq_done),
        .res       (seq_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (seq_done) begin
            m_tvalid_next = 1'b1;
            out_next      = seq_res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg};

`ifndef SYNTH
    // A new result must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_done |-> (!m_tvalid_reg || m_tready))
        else $error("result produced while the output register is still full");

    // The sequencer works on one request at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a previous one is still in work");

    // Every delivered date has a month in 1..12 and a day within that month's leap-year length.
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.month >= MONTH_JAN) && (out_reg.month <= MONTH_DEC))
        else $error("result month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.day != '0) &&
                     (out_reg.day <= month_len(out_reg.month, 1'b1)))
        else $error("result day out of range");
`endif

endmodule
